>>> hw/rtl/hrhp_pkg.sv
package hrhp_pkg;

	// parse phase of the request stream
	typedef enum logic [1:0] {
		PH_REQ  = 2'd0,
		PH_HDR  = 2'd1,
		PH_BODY = 2'd2,
		PH_ERR  = 2'd3
	} phase_t;

	// progress of the colon-space separator in a header line
	typedef enum logic [1:0] {
		COL_NONE = 2'd0,
		COL_JUST = 2'd1,
		COL_GOOD = 2'd2,
		COL_BAD  = 2'd3
	} colon_t;

	localparam logic [2:0] CLS_NONE     = 3'd0;
	localparam logic [2:0] CLS_METHOD   = 3'd1;
	localparam logic [2:0] CLS_RESOURCE = 3'd2;
	localparam logic [2:0] CLS_VERSION  = 3'd3;
	localparam logic [2:0] CLS_HNAME    = 3'd4;
	localparam logic [2:0] CLS_HVALUE   = 3'd5;
	localparam logic [2:0] CLS_BODY     = 3'd6;

	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_REQ_DONE = 2'd1;
	localparam logic [1:0] EV_HDR_DONE = 2'd2;
	localparam logic [1:0] EV_HDRS_END = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_BAD_REQ = 2'd1;
	localparam logic [1:0] ERR_TOO_BIG = 2'd2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam int          LEN_W     = 16;
	localparam logic [15:0] LEN_MAX   = 16'hFFFF;
	localparam logic [15:0] LIMIT_RST = 16'd512;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index taken from the word address
	localparam logic REG_REQ_LIMIT = 1'b0;
	localparam logic REG_HDR_LIMIT = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0] req_limit;
		logic [LEN_W-1:0] hdr_limit;
	} limits_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] byte_class;
		logic [1:0] line_event;
		logic [1:0] error_code;
		phase_t     parse_phase;
	} result_t;

endpackage

>>> hw/rtl/hrhp_cfg.sv
module hrhp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hrhp_pkg::APB_AW-1:0]   paddr,
	input  logic [hrhp_pkg::APB_DW-1:0]   pwdata,
	output logic [hrhp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output hrhp_pkg::limits_t             limits
);

	logic [hrhp_pkg::LEN_W-1:0] req_limit_q;
	logic [hrhp_pkg::LEN_W-1:0] hdr_limit_q;
	logic                       wr_en;
	logic                       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	// byte offset bits ignored, one register per word
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_limit_q <= hrhp_pkg::LIMIT_RST;
			hdr_limit_q <= hrhp_pkg::LIMIT_RST;
		end else if (wr_en) begin
			if (reg_idx == hrhp_pkg::REG_REQ_LIMIT) begin
				req_limit_q <= pwdata[hrhp_pkg::LEN_W-1:0];
			end else begin
				hdr_limit_q <= pwdata[hrhp_pkg::LEN_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == hrhp_pkg::REG_REQ_LIMIT) begin
			prdata[hrhp_pkg::LEN_W-1:0] = req_limit_q;
		end else begin
			prdata[hrhp_pkg::LEN_W-1:0] = hdr_limit_q;
		end
	end

	assign limits.req_limit = req_limit_q;
	assign limits.hdr_limit = hdr_limit_q;

endmodule

>>> hw/rtl/hrhp_core.sv
module hrhp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        byte_s1,
	input  logic              restart_s1,
	input  hrhp_pkg::limits_t limits,
	output hrhp_pkg::result_t result
);

	hrhp_pkg::phase_t           phase_q, ph_cur, ph_nxt;
	hrhp_pkg::colon_t           colon_q, col_cur, col_nxt;
	logic                       cr_q, cr_cur, cr_nxt;
	logic [hrhp_pkg::LEN_W-1:0] len_q, len_cur, len_nxt, len_inc, limit;
	logic [1:0]                 space_q, sp_cur, sp_nxt;
	logic [1:0]                 err_q, err_cur, err_nxt;
	logic [2:0]                 cls;
	logic [1:0]                 ev;

	always_comb begin
		// restart clears parser state ahead of the word
		ph_cur  = restart_s1 ? hrhp_pkg::PH_REQ   : phase_q;
		col_cur = restart_s1 ? hrhp_pkg::COL_NONE : colon_q;
		cr_cur  = restart_s1 ? 1'b0               : cr_q;
		len_cur = restart_s1 ? '0                 : len_q;
		sp_cur  = restart_s1 ? 2'd0               : space_q;
		err_cur = restart_s1 ? hrhp_pkg::ERR_NONE : err_q;

		len_inc = (len_cur != hrhp_pkg::LEN_MAX) ? len_cur + 1'b1 : len_cur;
		limit   = (ph_cur == hrhp_pkg::PH_REQ) ? limits.req_limit : limits.hdr_limit;

		ph_nxt  = ph_cur;
		col_nxt = col_cur;
		cr_nxt  = cr_cur;
		len_nxt = len_cur;
		sp_nxt  = sp_cur;
		err_nxt = err_cur;
		cls     = hrhp_pkg::CLS_NONE;
		ev      = hrhp_pkg::EV_NONE;

		case (ph_cur)
			hrhp_pkg::PH_BODY: begin
				cls = hrhp_pkg::CLS_BODY;
			end
			hrhp_pkg::PH_REQ, hrhp_pkg::PH_HDR: begin
				if (cr_cur) begin
					// line ends on cr lf, clear line state in every outcome
					cr_nxt  = 1'b0;
					len_nxt = '0;
					sp_nxt  = 2'd0;
					col_nxt = hrhp_pkg::COL_NONE;
					if (byte_s1 != hrhp_pkg::CH_LF) begin
						ph_nxt  = hrhp_pkg::PH_ERR;
						err_nxt = hrhp_pkg::ERR_BAD_REQ;
					end else if (ph_cur == hrhp_pkg::PH_REQ) begin
						if (sp_cur < 2'd2) begin
							ph_nxt  = hrhp_pkg::PH_ERR;
							err_nxt = hrhp_pkg::ERR_BAD_REQ;
						end else begin
							ev     = hrhp_pkg::EV_REQ_DONE;
							ph_nxt = hrhp_pkg::PH_HDR;
						end
					end else if (len_cur == '0) begin
						ev     = hrhp_pkg::EV_HDRS_END;
						ph_nxt = hrhp_pkg::PH_BODY;
					end else if (col_cur == hrhp_pkg::COL_GOOD) begin
						ev = hrhp_pkg::EV_HDR_DONE;
					end else begin
						ph_nxt  = hrhp_pkg::PH_ERR;
						err_nxt = hrhp_pkg::ERR_BAD_REQ;
					end
				end else if (byte_s1 == hrhp_pkg::CH_CR) begin
					cr_nxt = 1'b1;
				end else begin
					len_nxt = len_inc;
					if (len_inc > limit) begin
						ph_nxt  = hrhp_pkg::PH_ERR;
						err_nxt = hrhp_pkg::ERR_TOO_BIG;
						len_nxt = '0;
						sp_nxt  = 2'd0;
						col_nxt = hrhp_pkg::COL_NONE;
					end else if (ph_cur == hrhp_pkg::PH_REQ) begin
						if (byte_s1 == hrhp_pkg::CH_SPACE && sp_cur < 2'd2) begin
							sp_nxt = sp_cur + 2'd1;
						end else begin
							cls = hrhp_pkg::CLS_METHOD + {1'b0, sp_cur};
						end
					end else begin
						case (col_cur)
							hrhp_pkg::COL_NONE: begin
								if (byte_s1 == hrhp_pkg::CH_COLON) begin
									col_nxt = hrhp_pkg::COL_JUST;
								end else begin
									cls = hrhp_pkg::CLS_HNAME;
								end
							end
							hrhp_pkg::COL_JUST: begin
								if (byte_s1 == hrhp_pkg::CH_SPACE) begin
									col_nxt = hrhp_pkg::COL_GOOD;
								end else begin
									col_nxt = hrhp_pkg::COL_BAD;
									cls     = hrhp_pkg::CLS_HVALUE;
								end
							end
							default: begin
								cls = hrhp_pkg::CLS_HVALUE;
							end
						endcase
					end
				end
			end
			default: begin
				cls = hrhp_pkg::CLS_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrhp_pkg::PH_REQ;
			colon_q <= hrhp_pkg::COL_NONE;
			cr_q    <= 1'b0;
			len_q   <= '0;
			space_q <= 2'd0;
			err_q   <= hrhp_pkg::ERR_NONE;
		end else if (adv) begin
			phase_q <= ph_nxt;
			colon_q <= col_nxt;
			cr_q    <= cr_nxt;
			len_q   <= len_nxt;
			space_q <= sp_nxt;
			err_q   <= err_nxt;
		end
	end

	assign result.out_byte    = byte_s1;
	assign result.byte_class  = cls;
	assign result.line_event  = ev;
	assign result.error_code  = err_nxt;
	assign result.parse_phase = ph_nxt;

	a_err_phase : assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hrhp_pkg::PH_ERR) == (err_q != hrhp_pkg::ERR_NONE))
		else $error("error code and error phase disagree");

	a_space_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		space_q != 2'd3)
		else $error("space count past two");

	a_colon_hdr : assert property (@(posedge clk) disable iff (!arst_n)
		(colon_q != hrhp_pkg::COL_NONE) |-> (phase_q == hrhp_pkg::PH_HDR))
		else $error("colon state outside header phase");

	a_line_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hrhp_pkg::PH_BODY || phase_q == hrhp_pkg::PH_ERR)
		|-> (!cr_q && len_q == '0 && space_q == 2'd0))
		else $error("line state left over after line phases");

endmodule

>>> hw/rtl/http_request_header_parser_unit.sv
// http/1.1 request header tagger: every received byte word is passed through and tagged
// as method, resource, version, header name, header value, separator or body, along with
// line events, a sticky error code (bad request or line too long) and the parse
// phase after the byte. the unit takes one byte per clock unless the output stalls:
// a byte is held in the input register, the whole parse step runs as one short
// combinational pass over the parser state, and the tagged word lands in the output
// register. the next byte is taken in the same cycle as long as the output register is
// empty or being drained, so a stalled output holds one finished word and one waiting byte.
// restart on a byte returns the parser to the request-line phase before that byte is
// parsed; line limits live in two apb registers (request line at 0x0, header line at 0x4)
// and should only be written while no byte is in flight.
module http_request_header_parser_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hrhp_pkg::APB_AW-1:0] paddr,
	input  logic [hrhp_pkg::APB_DW-1:0] pwdata,
	output logic [hrhp_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	// input byte channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        restart,
	// tagged result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic [2:0]                  byte_class,
	output logic [1:0]                  line_event,
	output logic [1:0]                  error_code,
	output logic [1:0]                  parse_phase
);

	hrhp_pkg::limits_t limits;
	hrhp_pkg::result_t res_comb;
	hrhp_pkg::result_t res_s2;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       adv;
	logic       take_in;

	hrhp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	// output register can take a word when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// held byte moves through the parser into the output register
	assign adv      = valid_s1 && out_free;
	// input register frees up whenever its byte moves on
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1    <= in_byte;
			restart_s1 <= restart;
		end
	end

	// parser state and single-pass parse step
	hrhp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.byte_s1    (byte_s1),
		.restart_s1 (restart_s1),
		.limits     (limits),
		.result     (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = res_s2.out_byte;
	assign byte_class  = res_s2.byte_class;
	assign line_event  = res_s2.line_event;
	assign error_code  = res_s2.error_code;
	assign parse_phase = res_s2.parse_phase;

endmodule
